@@ sv/nppr_pkg.sv @@
// Shared types, constants and helpers for the nearest palette recolour core.
package nppr_pkg;

    // Field and port widths.
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int COUNT_W    = 3;
    localparam int DIST_W     = 18;  // 3 * 255^2 fits in 18 bits
    localparam int NUM_STAGES = 5;

    // Number of map slots in the register list and the default depth held.
    localparam int MAP_SLOTS       = 7;
    localparam int DEF_MAX_ENTRIES = 7;

    // Neutral pixel thresholds and the channel ceiling.
    localparam logic [CHAN_W-1:0] WHITE_LEVEL = 8'd235;
    localparam logic [CHAN_W-1:0] BLACK_LEVEL = 8'd40;
    localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_ENTRY_0 = 3'd1;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    // Pixel plus its pass-through decision, carried down the pipeline.
    typedef struct packed {
        pix_t pix;
        logic skip;
    } meta_t;

    // One map entry, packed as in the configuration register.
    typedef struct packed {
        logic [CHAN_W-1:0] src_red;
        logic [CHAN_W-1:0] src_green;
        logic [CHAN_W-1:0] src_blue;
        logic [CHAN_W-1:0] dst_red;
        logic [CHAN_W-1:0] dst_green;
        logic [CHAN_W-1:0] dst_blue;
    } entry_t;

    // Shift a channel by (dst - src) and clamp it to 0..255.
    function automatic logic [CHAN_W-1:0] sat_chan(
        input logic [CHAN_W-1:0] pix,
        input logic [CHAN_W-1:0] src,
        input logic [CHAN_W-1:0] dst
    );
        logic [CHAN_W+1:0] sum;
        logic [CHAN_W-1:0] res;
        begin
            sum = {2'b00, dst} + {2'b00, pix} - {2'b00, src};
            if (sum[CHAN_W+1])
            begin
                res = '0;
            end
            else if (sum[CHAN_W])
            begin
                res = CHAN_MAX;
            end
            else
            begin
                res = sum[CHAN_W-1:0];
            end
            return res;
        end
    endfunction

endpackage

@@ sv/nppr_if.sv @@
// Stream and configuration interfaces of the nearest palette recolour core.
interface nppr_pix_if;
    logic                        valid;
    logic                        ready;
    logic [nppr_pkg::CHAN_W-1:0] in_alpha;
    logic [nppr_pkg::CHAN_W-1:0] in_red;
    logic [nppr_pkg::CHAN_W-1:0] in_green;
    logic [nppr_pkg::CHAN_W-1:0] in_blue;

    modport source (output valid, in_alpha, in_red, in_green, in_blue, input ready);
    modport sink (input valid, in_alpha, in_red, in_green, in_blue, output ready);
endinterface

interface nppr_res_if;
    logic                        valid;
    logic                        ready;
    logic [nppr_pkg::CHAN_W-1:0] out_alpha;
    logic [nppr_pkg::CHAN_W-1:0] out_red;
    logic [nppr_pkg::CHAN_W-1:0] out_green;
    logic [nppr_pkg::CHAN_W-1:0] out_blue;
    logic                        was_recoloured;

    modport source (output valid, out_alpha, out_red, out_green, out_blue, was_recoloured,
                    input ready);
    modport sink (input valid, out_alpha, out_red, out_green, out_blue, was_recoloured,
                  output ready);
endinterface

interface nppr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [nppr_pkg::CFG_IDX_W-1:0]  index;
    logic [nppr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/nppr_dist.sv @@
// Distance stages: pass-through decision, channel differences and squared distances.
module nppr_dist #(
    parameter int MAX_ENTRIES = nppr_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                              clk,
    input  logic [1:0]                                        ld,
    input  nppr_pkg::pix_t                                    pix,
    input  logic [nppr_pkg::COUNT_W-1:0]                      entry_count,
    input  nppr_pkg::entry_t [MAX_ENTRIES-1:0]                entries,
    output nppr_pkg::meta_t                                   meta,
    output logic [MAX_ENTRIES-1:0][nppr_pkg::DIST_W-1:0]      sq_dist,
    output logic [MAX_ENTRIES-1:0]                            ent_ok
);

    localparam int CW = nppr_pkg::CHAN_W;
    localparam int SQ_W = 2 * CW;

    logic [nppr_pkg::COUNT_W-1:0]           count_eff;
    logic                                   white;
    logic                                   black;
    nppr_pkg::meta_t                        s1_meta_next;
    nppr_pkg::meta_t                        s1_meta_reg;
    logic [MAX_ENTRIES-1:0][2:0][CW-1:0]    s1_diff_next;
    logic [MAX_ENTRIES-1:0][2:0][CW-1:0]    s1_diff_reg;
    logic [MAX_ENTRIES-1:0]                 s1_ok_next;
    logic [MAX_ENTRIES-1:0]                 s1_ok_reg;
    logic [MAX_ENTRIES-1:0][nppr_pkg::DIST_W-1:0] s2_dist_next;
    logic [MAX_ENTRIES-1:0][nppr_pkg::DIST_W-1:0] s2_dist_reg;
    nppr_pkg::meta_t                        s2_meta_reg;
    logic [MAX_ENTRIES-1:0]                 s2_ok_reg;

    // Clamp the live entry count to the number of slots held.
    always_comb
    begin
        if (entry_count > nppr_pkg::COUNT_W'(MAX_ENTRIES))
        begin
            count_eff = nppr_pkg::COUNT_W'(MAX_ENTRIES);
        end
        else
        begin
            count_eff = entry_count;
        end
    end

    // Neutral tests and the pass-through decision.
    always_comb
    begin
        white = (pix.red > nppr_pkg::WHITE_LEVEL) && (pix.green > nppr_pkg::WHITE_LEVEL)
                && (pix.blue > nppr_pkg::WHITE_LEVEL);
        black = (pix.red < nppr_pkg::BLACK_LEVEL) && (pix.green < nppr_pkg::BLACK_LEVEL)
                && (pix.blue < nppr_pkg::BLACK_LEVEL);
        s1_meta_next.pix  = pix;
        s1_meta_next.skip = (pix.alpha == '0) || white || black || (count_eff == '0);
    end

    // Absolute channel differences against every source colour.
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            s1_diff_next[i][0] = (pix.red > entries[i].src_red)
                               ? pix.red - entries[i].src_red : entries[i].src_red - pix.red;
            s1_diff_next[i][1] = (pix.green > entries[i].src_green)
                               ? pix.green - entries[i].src_green
                               : entries[i].src_green - pix.green;
            s1_diff_next[i][2] = (pix.blue > entries[i].src_blue)
                               ? pix.blue - entries[i].src_blue : entries[i].src_blue - pix.blue;
            s1_ok_next[i] = (nppr_pkg::COUNT_W'(i) < count_eff);
        end
    end

    // Stage 1 registers.
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s1_meta_reg <= s1_meta_next;
            s1_diff_reg <= s1_diff_next;
            s1_ok_reg   <= s1_ok_next;
        end
    end

    // Squares of the differences, summed per entry.
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            logic [SQ_W-1:0] sq_r;
            logic [SQ_W-1:0] sq_g;
            logic [SQ_W-1:0] sq_b;
            sq_r = {{CW{1'b0}}, s1_diff_reg[i][0]} * {{CW{1'b0}}, s1_diff_reg[i][0]};
            sq_g = {{CW{1'b0}}, s1_diff_reg[i][1]} * {{CW{1'b0}}, s1_diff_reg[i][1]};
            sq_b = {{CW{1'b0}}, s1_diff_reg[i][2]} * {{CW{1'b0}}, s1_diff_reg[i][2]};
            s2_dist_next[i] = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};
        end
    end

    // Stage 2 registers.
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s2_meta_reg <= s1_meta_reg;
            s2_dist_reg <= s2_dist_next;
            s2_ok_reg   <= s1_ok_reg;
        end
    end

    assign meta    = s2_meta_reg;
    assign sq_dist = s2_dist_reg;
    assign ent_ok  = s2_ok_reg;

endmodule

@@ sv/nppr_argmin.sv @@
// Argmin stages: pairwise reduction, then a short scan to the nearest entry index.
module nppr_argmin #(
    parameter int MAX_ENTRIES = nppr_pkg::DEF_MAX_ENTRIES,
    parameter int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                                          clk,
    input  logic [1:0]                                    ld,
    input  nppr_pkg::meta_t                               meta_in,
    input  logic [MAX_ENTRIES-1:0][nppr_pkg::DIST_W-1:0]  sq_dist,
    input  logic [MAX_ENTRIES-1:0]                        ent_ok,
    output nppr_pkg::meta_t                               meta_out,
    output logic [IDX_W-1:0]                              best_idx
);

    localparam int NP = (MAX_ENTRIES + 1) / 2;

    logic [NP-1:0][nppr_pkg::DIST_W-1:0] s3_dist_next;
    logic [NP-1:0][IDX_W-1:0]            s3_idx_next;
    logic [NP-1:0]                       s3_ok_next;
    logic [NP-1:0][nppr_pkg::DIST_W-1:0] s3_dist_reg;
    logic [NP-1:0][IDX_W-1:0]            s3_idx_reg;
    logic [NP-1:0]                       s3_ok_reg;
    nppr_pkg::meta_t                     s3_meta_reg;
    logic [IDX_W-1:0]                    s4_idx_next;
    logic [IDX_W-1:0]                    s4_idx_reg;
    nppr_pkg::meta_t                     s4_meta_reg;

    // First level: each pair keeps its nearer valid entry, lower index on a tie.
    for (genvar k = 0; k < NP; k++)
    begin : g_pair
        if (2 * k + 1 < MAX_ENTRIES)
        begin : g_two
            always_comb
            begin
                if (ent_ok[2*k] && (!ent_ok[2*k+1] || (sq_dist[2*k] <= sq_dist[2*k+1])))
                begin
                    s3_dist_next[k] = sq_dist[2*k];
                    s3_idx_next[k]  = IDX_W'(2 * k);
                end
                else
                begin
                    s3_dist_next[k] = sq_dist[2*k+1];
                    s3_idx_next[k]  = IDX_W'(2 * k + 1);
                end
                s3_ok_next[k] = ent_ok[2*k] || ent_ok[2*k+1];
            end
        end
        else
        begin : g_one
            always_comb
            begin
                s3_dist_next[k] = sq_dist[2*k];
                s3_idx_next[k]  = IDX_W'(2 * k);
                s3_ok_next[k]   = ent_ok[2*k];
            end
        end
    end

    // Stage 3 registers.
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s3_meta_reg <= meta_in;
            s3_dist_reg <= s3_dist_next;
            s3_idx_reg  <= s3_idx_next;
            s3_ok_reg   <= s3_ok_next;
        end
    end

    // Second level: scan the pair winners in index order, strictly nearer wins.
    always_comb
    begin
        logic [nppr_pkg::DIST_W-1:0] best_dist;
        best_dist   = s3_dist_reg[0];
        s4_idx_next = s3_idx_reg[0];
        for (int k = 1; k < NP; k++)
        begin
            if (s3_ok_reg[k] && (s3_dist_reg[k] < best_dist))
            begin
                best_dist   = s3_dist_reg[k];
                s4_idx_next = s3_idx_reg[k];
            end
        end
    end

    // Stage 4 registers.
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s4_meta_reg <= s3_meta_reg;
            s4_idx_reg  <= s4_idx_next;
        end
    end

    assign meta_out = s4_meta_reg;
    assign best_idx = s4_idx_reg;

endmodule

@@ sv/nppr_apply.sv @@
// Apply stage: shift the pixel by the chosen entry's offset and hold the result beat.
module nppr_apply #(
    parameter int MAX_ENTRIES = nppr_pkg::DEF_MAX_ENTRIES,
    parameter int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                               clk,
    input  logic                               ld,
    input  nppr_pkg::meta_t                    meta,
    input  logic [IDX_W-1:0]                   best_idx,
    input  nppr_pkg::entry_t [MAX_ENTRIES-1:0] entries,
    output nppr_pkg::pix_t                     res_pix,
    output logic                               res_recoloured
);

    nppr_pkg::entry_t sel;
    nppr_pkg::pix_t   pix_next;
    nppr_pkg::pix_t   pix_reg;
    logic             rec_reg;

    // Recolour unless the pixel is passed through; alpha always carries over.
    always_comb
    begin
        sel = entries[best_idx];
        pix_next.alpha = meta.pix.alpha;
        if (meta.skip)
        begin
            pix_next = meta.pix;
        end
        else
        begin
            pix_next.red   = nppr_pkg::sat_chan(meta.pix.red, sel.src_red, sel.dst_red);
            pix_next.green = nppr_pkg::sat_chan(meta.pix.green, sel.src_green, sel.dst_green);
            pix_next.blue  = nppr_pkg::sat_chan(meta.pix.blue, sel.src_blue, sel.dst_blue);
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            pix_reg <= pix_next;
            rec_reg <= !meta.skip;
        end
    end

    assign res_pix        = pix_reg;
    assign res_recoloured = rec_reg;

endmodule

@@ sv/nearest_palette_pixel_recolour_core.sv @@
// Nearest palette recolour core: five-stage pipeline, one pixel beat per clock.
// Stages: an accepted pixel passes through difference, distance, pair reduce, scan and apply
// in that order, and is offered as a result once the apply stage has registered it.
// Throughput: one beat per cycle; a stalled output backs the stages up without loss.
// Reset: rst_n clears all stage valid bits, the entry count and every map entry to zero.
module nearest_palette_pixel_recolour_core #(
    parameter int MAX_ENTRIES = nppr_pkg::DEF_MAX_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    nppr_pix_if.sink   pixel,
    nppr_res_if.source result,
    nppr_cfg_if.sink   cfg
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NS = nppr_pkg::NUM_STAGES;

    logic [nppr_pkg::COUNT_W-1:0]       entry_count_reg;
    nppr_pkg::entry_t [MAX_ENTRIES-1:0] entry_reg;
    logic [NS-1:0]                      v_reg;
    logic [NS-1:0]                      v_next;
    logic [NS-1:0]                      rdy;
    nppr_pkg::pix_t                     in_pix;
    nppr_pkg::meta_t                    dist_meta;
    logic [MAX_ENTRIES-1:0][nppr_pkg::DIST_W-1:0] sq_dist;
    logic [MAX_ENTRIES-1:0]             ent_ok;
    nppr_pkg::meta_t                    scan_meta;
    logic [IDX_W-1:0]                   best_idx;
    nppr_pkg::pix_t                     res_pix;
    logic                               res_recoloured;

    // Configuration writes; only slots that are held are stored.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            entry_reg       <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == nppr_pkg::REG_ENTRY_COUNT)
            begin
                entry_count_reg <= cfg.data[nppr_pkg::COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (cfg.index == nppr_pkg::CFG_IDX_W'(int'(nppr_pkg::REG_MAP_ENTRY_0) + i))
                begin
                    entry_reg[i] <= nppr_pkg::entry_t'(cfg.data);
                end
            end
        end
    end

    // Per-stage ready: a stage loads when it is empty or its beat moves on.
    always_comb
    begin
        rdy[NS-1] = !v_reg[NS-1] || result.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? pixel.valid : v_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign pixel.ready = rdy[0];
    assign in_pix = {pixel.in_alpha, pixel.in_red, pixel.in_green, pixel.in_blue};

    // Stages 1 and 2.
    nppr_dist #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dist (
        .clk         (clk),
        .ld          (rdy[1:0]),
        .pix         (in_pix),
        .entry_count (entry_count_reg),
        .entries     (entry_reg),
        .meta        (dist_meta),
        .sq_dist     (sq_dist),
        .ent_ok      (ent_ok)
    );

    // Stages 3 and 4.
    nppr_argmin #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_argmin (
        .clk      (clk),
        .ld       (rdy[3:2]),
        .meta_in  (dist_meta),
        .sq_dist  (sq_dist),
        .ent_ok   (ent_ok),
        .meta_out (scan_meta),
        .best_idx (best_idx)
    );

    // Stage 5, the output register.
    nppr_apply #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_apply (
        .clk            (clk),
        .ld             (rdy[4]),
        .meta           (scan_meta),
        .best_idx       (best_idx),
        .entries        (entry_reg),
        .res_pix        (res_pix),
        .res_recoloured (res_recoloured)
    );

    assign result.valid          = v_reg[NS-1];
    assign result.out_alpha      = res_pix.alpha;
    assign result.out_red        = res_pix.red;
    assign result.out_green      = res_pix.green;
    assign result.out_blue       = res_pix.blue;
    assign result.was_recoloured = res_recoloured;

endmodule
